// ===== design/cdr_pkg.sv =====
`default_nettype none

package cdr_pkg;

  // Date range limits
  localparam logic [13:0] MAX_YEAR  = 14'd9999;
  localparam logic [13:0] MIN_YEAR  = 14'd1700;
  localparam logic [3:0]  MIN_MONTH = 4'd3;
  localparam logic [4:0]  MIN_DAY   = 5'd1;

  // Action codes
  typedef enum logic [2:0] {
    ACT_LOAD      = 3'd0,
    ACT_SET_YEAR  = 3'd1,
    ACT_SET_MONTH = 3'd2,
    ACT_SET_DAY   = 3'd3,
    ACT_NEXT      = 3'd4,
    ACT_PREV      = 3'd5,
    ACT_READ      = 3'd6
  } action_t;

  // Operands of one item after the decimal split
  typedef struct packed {
    logic [2:0]  act;
    logic [13:0] ld_year;
    logic [6:0]  ld_month;
    logic [6:0]  ld_day;
    logic        ld_leap;
    logic [13:0] set_val;
    logic        sy_ok;
    logic        sy_leap;
    logic        sm_ok;
    logic        sd_ok;
  } op_t;

  // Date held after one item
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        leap;
    logic        rej;
  } date_t;

  // Load enables of the front stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pipe_en_t;

  // Control of the state stage
  typedef struct packed {
    logic load;
    logic take;
  } step_ctl_t;

  // Gregorian leap test; y/100 by reciprocal, exact below 43699
  function automatic logic is_leap(input logic [13:0] y);
    logic [26:0] prod;
    logic [7:0]  q;
    logic [13:0] r;
    prod = 27'(y) * 27'd5243;
    q    = prod[26:19];
    r    = y - (14'(q) * 14'd100);
    return ((y[1:0] == 2'b00) && (r != 14'd0)) || ((r == 14'd0) && (q[1:0] == 2'b00));
  endfunction

  // Month length; zero for a month that does not exist
  function automatic logic [4:0] days_in(input logic lp, input logic [3:0] m);
    logic [4:0] n;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                        n = lp ? 5'd29 : 5'd28;
      default:                                     n = 5'd0;
    endcase
    return n;
  endfunction

  // Days before the first of month m in a common year
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] s;
    case (m)
      4'd1:    s = 9'd0;
      4'd2:    s = 9'd31;
      4'd3:    s = 9'd59;
      4'd4:    s = 9'd90;
      4'd5:    s = 9'd120;
      4'd6:    s = 9'd151;
      4'd7:    s = 9'd181;
      4'd8:    s = 9'd212;
      4'd9:    s = 9'd243;
      4'd10:   s = 9'd273;
      4'd11:   s = 9'd304;
      4'd12:   s = 9'd334;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] quarter_of(input logic [3:0] m);
    logic [2:0] q;
    case (m) inside
      4'd4, 4'd5, 4'd6:    q = 3'd2;
      4'd7, 4'd8, 4'd9:    q = 3'd3;
      4'd10, 4'd11, 4'd12: q = 3'd4;
      default:             q = 3'd1;
    endcase
    return q;
  endfunction

endpackage

`default_nettype wire

// ===== design/cdr_split.sv =====
`default_nettype none

module cdr_split (
  input  wire logic             clk,
  input  wire cdr_pkg::pipe_en_t en,
  input  wire logic [2:0]       action,
  input  wire logic [26:0]      value,
  output cdr_pkg::op_t          op
);

  // Reciprocals for value/100 and value/10000, exact for 32-bit operands
  localparam logic [57:0] DIV100_MUL  = 58'd1374389535;
  localparam int          DIV100_SHR  = 37;
  localparam logic [58:0] DIV10K_MUL  = 59'd3518437209;
  localparam int          DIV10K_SHR  = 45;

  // Stage 1: input register
  logic [2:0]  act1;
  logic [26:0] val1;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      act1 <= action;
      val1 <= value;
    end
  end

  // Divide by 100 and by 10000, range-check the set operands
  logic [57:0] p100;
  logic [58:0] p10k;
  logic [6:0]  q7;
  logic [13:0] ly;
  logic        sy_ok1, sm_ok1, sd_ok1;

  always_comb begin
    p100   = 58'(val1) * DIV100_MUL;
    p10k   = 59'(val1) * DIV10K_MUL;
    q7     = p100[DIV100_SHR +: 7];
    ly     = p10k[DIV10K_SHR +: 14];
    sy_ok1 = (val1 >= 27'(cdr_pkg::MIN_YEAR)) && (val1 <= 27'(cdr_pkg::MAX_YEAR));
    sm_ok1 = (val1 >= 27'd1) && (val1 <= 27'd12);
    sd_ok1 = (val1 >= 27'd1) && (val1 <= 27'd31);
  end

  // Stage 2 register
  logic [2:0]  act2;
  logic [13:0] val2;
  logic [6:0]  q2;
  logic [13:0] ly2;
  logic        sy_ok2, sm_ok2, sd_ok2;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      act2   <= act1;
      val2   <= val1[13:0];
      q2     <= q7;
      ly2    <= ly;
      sy_ok2 <= sy_ok1;
      sm_ok2 <= sm_ok1;
      sd_ok2 <= sd_ok1;
    end
  end

  // Remainders fit in 7 bits, so work modulo 128
  logic [13:0] q_x100;
  logic [13:0] y_x100;
  logic [6:0]  ld_day, ld_month;
  logic        ld_leap, sy_leap;

  always_comb begin
    q_x100   = 14'(q2) * 14'd100;
    y_x100   = 14'(ly2[6:0]) * 14'd100;
    ld_day   = val2[6:0] - q_x100[6:0];
    ld_month = q2 - y_x100[6:0];
    ld_leap  = cdr_pkg::is_leap(ly2);
    sy_leap  = cdr_pkg::is_leap(val2);
  end

  // Stage 3 register: operands ready for the state update
  always_ff @(posedge clk) begin
    if (en.s3) begin
      op.act      <= act2;
      op.ld_year  <= ly2;
      op.ld_month <= ld_month;
      op.ld_day   <= ld_day;
      op.ld_leap  <= ld_leap;
      op.set_val  <= val2;
      op.sy_ok    <= sy_ok2;
      op.sy_leap  <= sy_leap;
      op.sm_ok    <= sm_ok2;
      op.sd_ok    <= sd_ok2;
    end
  end

endmodule

`default_nettype wire

// ===== design/cdr_state.sv =====
`default_nettype none

module cdr_state (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cdr_pkg::step_ctl_t ctl,
  input  wire cdr_pkg::op_t       op,
  output cdr_pkg::date_t          date
);

  // Current date
  logic [13:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic        leap_cur;

  logic [4:0]  dim_cur;
  logic        leap_up, leap_dn;
  logic [13:0] cy;
  logic [3:0]  cm;
  logic [4:0]  cd;
  logic        cl;
  logic        ok;
  logic [13:0] year_next;
  logic [3:0]  month_next;
  logic [4:0]  day_next;
  logic        leap_next;

  assign leap_up = cdr_pkg::is_leap(year + 14'd1);
  assign leap_dn = cdr_pkg::is_leap(year - 14'd1);

  // Build the candidate date and check it
  always_comb begin
    dim_cur = cdr_pkg::days_in(leap_cur, month);
    cy = year;
    cm = month;
    cd = day;
    cl = leap_cur;
    ok = 1'b1;
    case (op.act)
      cdr_pkg::ACT_LOAD: begin
        cy = op.ld_year;
        cm = op.ld_month[3:0];
        cd = op.ld_day[4:0];
        cl = op.ld_leap;
        ok = (op.ld_year <= cdr_pkg::MAX_YEAR)
          && (op.ld_month >= 7'd1) && (op.ld_month <= 7'd12)
          && (op.ld_day >= 7'd1)
          && (op.ld_day <= {2'b00, cdr_pkg::days_in(op.ld_leap, op.ld_month[3:0])})
          && ((op.ld_year > cdr_pkg::MIN_YEAR)
            || ((op.ld_year == cdr_pkg::MIN_YEAR)
              && (op.ld_month >= 7'(cdr_pkg::MIN_MONTH))));
      end
      cdr_pkg::ACT_SET_YEAR: begin
        cy = op.set_val;
        cl = op.sy_leap;
        ok = op.sy_ok && (day <= cdr_pkg::days_in(op.sy_leap, month))
          && ((op.set_val > cdr_pkg::MIN_YEAR) || (month >= cdr_pkg::MIN_MONTH));
      end
      cdr_pkg::ACT_SET_MONTH: begin
        cm = op.set_val[3:0];
        ok = op.sm_ok && (day <= cdr_pkg::days_in(leap_cur, op.set_val[3:0]))
          && ((year > cdr_pkg::MIN_YEAR) || (op.set_val[3:0] >= cdr_pkg::MIN_MONTH));
      end
      cdr_pkg::ACT_SET_DAY: begin
        cd = op.set_val[4:0];
        ok = op.sd_ok && (op.set_val[4:0] <= dim_cur);
      end
      cdr_pkg::ACT_NEXT: begin
        if (day < dim_cur) begin
          cd = day + 5'd1;
        end else if (month < 4'd12) begin
          cm = month + 4'd1;
          cd = 5'd1;
        end else begin
          cy = year + 14'd1;
          cm = 4'd1;
          cd = 5'd1;
          cl = leap_up;
          ok = year < cdr_pkg::MAX_YEAR;
        end
      end
      cdr_pkg::ACT_PREV: begin
        if (day > 5'd1) begin
          cd = day - 5'd1;
        end else if (month > 4'd1) begin
          cm = month - 4'd1;
          cd = cdr_pkg::days_in(leap_cur, month - 4'd1);
          ok = (year > cdr_pkg::MIN_YEAR) || ((month - 4'd1) >= cdr_pkg::MIN_MONTH);
        end else begin
          cy = year - 14'd1;
          cm = 4'd12;
          cd = 5'd31;
          cl = leap_dn;
          ok = year > cdr_pkg::MIN_YEAR;
        end
      end
      default: ok = 1'b1;
    endcase
    year_next  = ok ? cy : year;
    month_next = ok ? cm : month;
    day_next   = ok ? cd : day;
    leap_next  = ok ? cl : leap_cur;
  end

  // Commit the date when the item leaves this stage
  always_ff @(posedge clk) begin
    if (rst) begin
      year     <= cdr_pkg::MIN_YEAR;
      month    <= cdr_pkg::MIN_MONTH;
      day      <= cdr_pkg::MIN_DAY;
      leap_cur <= 1'b0;
    end else if (ctl.take) begin
      year     <= year_next;
      month    <= month_next;
      day      <= day_next;
      leap_cur <= leap_next;
    end
  end

  // Hand the resulting date to the output stage
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      date.year  <= year_next;
      date.month <= month_next;
      date.day   <= day_next;
      date.leap  <= leap_next;
      date.rej   <= !ok;
    end
  end

`ifndef NO_ASSERTIONS
  a_date_valid: assert property (@(posedge clk) disable iff (rst)
    (month >= 4'd1) && (month <= 4'd12) && (day >= 5'd1)
      && (day <= cdr_pkg::days_in(leap_cur, month))
      && (year >= cdr_pkg::MIN_YEAR) && (year <= cdr_pkg::MAX_YEAR)
      && ((year > cdr_pkg::MIN_YEAR) || (month >= cdr_pkg::MIN_MONTH)))
    else $error("held date out of range");
  a_leap_tracks: assert property (@(posedge clk) disable iff (rst)
    leap_cur == cdr_pkg::is_leap(year))
    else $error("leap flag does not match year");
  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    (ctl.take && !ok) |=> ((year == $past(year)) && (month == $past(month))
      && (day == $past(day))))
    else $error("rejected item changed the date");
`endif

endmodule

`default_nettype wire

// ===== design/cdr_format.sv =====
`default_nettype none

module cdr_format (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire cdr_pkg::date_t date,
  output logic [26:0]         packed_date,
  output logic [13:0]         year_out,
  output logic [3:0]          month_out,
  output logic [4:0]          day_out,
  output logic [2:0]          quarter,
  output logic [8:0]          day_of_year,
  output logic [8:0]          days_left,
  output logic                leap,
  output logic                rejected
);

  logic [26:0] packed_c;
  logic [8:0]  doy_c;
  logic [8:0]  ylen;

  // Derive the packed value, ordinal day and days left
  always_comb begin
    packed_c = (27'(date.year) * 27'd10000) + (27'(date.month) * 27'd100) + 27'(date.day);
    doy_c    = cdr_pkg::month_start(date.month) + 9'(date.day)
             + 9'(date.leap && (date.month > 4'd2));
    ylen     = date.leap ? 9'd366 : 9'd365;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (en) begin
      packed_date <= packed_c;
      year_out    <= date.year;
      month_out   <= date.month;
      day_out     <= date.day;
      quarter     <= cdr_pkg::quarter_of(date.month);
      day_of_year <= doy_c;
      days_left   <= ylen - doy_c;
      leap        <= date.leap;
      rejected    <= date.rej;
    end
  end

endmodule

`default_nettype wire

// ===== design/calendar_date_register.sv =====
`default_nettype none

// Channel  Handshake             Payload
// in       in_valid / in_ready   action, value
// out      out_valid / out_ready packed_date, year_out, month_out, day_out,
//                                quarter, day_of_year, days_left, leap, rejected
//
// One item per cycle while out_ready does not stall the pipeline.
// Five register stages: input, decimal split, operand, date state, result.
// The date register is updated once per item, so items follow back to back.
// rst (synchronous) empties the pipeline and sets the date to 1700-03-01.
// A stalled result holds; earlier stages keep filling until every stage is full.

module calendar_date_register (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  action,
  input  wire logic [26:0] value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [26:0]      packed_date,
  output logic [13:0]      year_out,
  output logic [3:0]       month_out,
  output logic [4:0]       day_out,
  output logic [2:0]       quarter,
  output logic [8:0]       day_of_year,
  output logic [8:0]       days_left,
  output logic             leap,
  output logic             rejected
);

  logic v1, v2, v3, v4;
  logic en_out, en4, en3, en2, en1;
  cdr_pkg::pipe_en_t  pen;
  cdr_pkg::step_ctl_t sctl;
  cdr_pkg::op_t       op;
  cdr_pkg::date_t     date;

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    en_out    = !out_valid || out_ready;
    en4       = !v4 || en_out;
    en3       = !v3 || en4;
    en2       = !v2 || en3;
    en1       = !v1 || en2;
    in_ready  = en1;
    pen.s1    = en1;
    pen.s2    = en2;
    pen.s3    = en3;
    sctl.load = en4;
    sctl.take = en4 && v3;
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1)    v1        <= in_valid;
      if (en2)    v2        <= v1;
      if (en3)    v3        <= v2;
      if (en4)    v4        <= v3;
      if (en_out) out_valid <= v4;
    end
  end

  cdr_split u_split (
    .clk    (clk),
    .en     (pen),
    .action (action),
    .value  (value),
    .op     (op)
  );

  cdr_state u_state (
    .clk  (clk),
    .rst  (rst),
    .ctl  (sctl),
    .op   (op),
    .date (date)
  );

  cdr_format u_format (
    .clk         (clk),
    .en          (en_out),
    .date        (date),
    .packed_date (packed_date),
    .year_out    (year_out),
    .month_out   (month_out),
    .day_out     (day_out),
    .quarter     (quarter),
    .day_of_year (day_of_year),
    .days_left   (days_left),
    .leap        (leap),
    .rejected    (rejected)
  );

`ifndef NO_ASSERTIONS
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && v4 && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken with a full pipeline");
  a_result_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(v4))
    else $error("result shown without an item behind it");
  a_bubble_fills: assert property (@(posedge clk) disable iff (rst)
    (!v1 && !v2 && !v3 && !v4) |-> in_ready)
    else $error("empty pipeline refuses input");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_calendar_date_register.sv =====
localparam longint unsigned MIN_PACKED =
  longint'(cdr_pkg::MIN_YEAR) * 10000 + longint'(cdr_pkg::MIN_MONTH) * 100
  + longint'(cdr_pkg::MIN_DAY);
localparam logic [2:0] ACT_SPARE = 3'd7;

// One result item at the widths of the output ports
typedef struct {
  logic [26:0] packed_date;
  logic [13:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [2:0]  quarter;
  logic [8:0]  day_of_year;
  logic [8:0]  days_left;
  logic        leap;
  logic        rejected;
} date_result_t;

function automatic bit leap_year(longint unsigned y);
  return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
endfunction

function automatic int unsigned month_len(longint unsigned y, longint unsigned m);
  if (m < 1 || m > 12) return 0;
  if (m == 2) return leap_year(y) ? 29 : 28;
  if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
  return 31;
endfunction

// Track the held date and the queue of results still to come
class date_scoreboard;
  int unsigned  cur_year;
  int unsigned  cur_month;
  int unsigned  cur_day;
  date_result_t expected_dates[$];
  int unsigned  fail_count;
  int unsigned  result_index;

  function new();
    cur_year     = cdr_pkg::MIN_YEAR;
    cur_month    = cdr_pkg::MIN_MONTH;
    cur_day      = cdr_pkg::MIN_DAY;
    fail_count   = 0;
    result_index = 0;
  endfunction

  function int pending();
    return expected_dates.size();
  endfunction

  task report_mismatch(string what);
    fail_count++;
    $display("mismatch at result %0d: %s", result_index, what);
  endtask

  // Take the candidate date only if it is a real date inside the range
  function bit try_commit(longint unsigned y, longint unsigned m, longint unsigned d);
    if (y > cdr_pkg::MAX_YEAR || m < 1 || m > 12 || d < 1 || d > month_len(y, m))
      return 0;
    if (y * 10000 + m * 100 + d < MIN_PACKED) return 0;
    cur_year  = 32'(y);
    cur_month = 32'(m);
    cur_day   = 32'(d);
    return 1;
  endfunction

  // Apply one accepted item and queue the date it leaves behind
  function void note_item(logic [2:0] act, logic [26:0] val);
    longint unsigned y, m, d, v;
    bit              rej;
    bit              lp;
    int unsigned     doy;
    date_result_t    r;
    y   = cur_year;
    m   = cur_month;
    d   = cur_day;
    v   = val;
    rej = 0;
    case (act)
      cdr_pkg::ACT_LOAD:      rej = !try_commit(v / 10000, (v / 100) % 100, v % 100);
      cdr_pkg::ACT_SET_YEAR:  rej = (v < cdr_pkg::MIN_YEAR) ? 1'b1 : !try_commit(v, m, d);
      cdr_pkg::ACT_SET_MONTH: rej = !try_commit(y, v, d);
      cdr_pkg::ACT_SET_DAY:   rej = !try_commit(y, m, v);
      cdr_pkg::ACT_NEXT: begin
        if (d < month_len(y, m)) begin
          d++;
        end else if (m < 12) begin
          m++;
          d = 1;
        end else begin
          y++;
          m = 1;
          d = 1;
        end
        rej = !try_commit(y, m, d);
      end
      cdr_pkg::ACT_PREV: begin
        if (d > 1) begin
          d--;
        end else if (m > 1) begin
          m--;
          d = month_len(y, m);
        end else begin
          y--;
          m = 12;
          d = 31;
        end
        rej = !try_commit(y, m, d);
      end
      default: rej = 0;
    endcase
    lp  = leap_year(cur_year);
    doy = cur_day;
    for (int k = 1; k < cur_month; k++) doy += month_len(cur_year, k);
    r.packed_date = 27'(cur_year * 10000 + cur_month * 100 + cur_day);
    r.year        = 14'(cur_year);
    r.month       = 4'(cur_month);
    r.day         = 5'(cur_day);
    r.quarter     = 3'((cur_month - 1) / 3 + 1);
    r.day_of_year = 9'(doy);
    r.days_left   = 9'((lp ? 366 : 365) - doy);
    r.leap        = lp;
    r.rejected    = rej;
    expected_dates.push_back(r);
  endfunction

  task compare_field(string name, logic [26:0] got, logic [26:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Match one result against the oldest expectation
  task check_result(date_result_t seen);
    date_result_t want;
    result_index++;
    if (expected_dates.size() == 0) begin
      report_mismatch("result with no item waiting");
      return;
    end
    want = expected_dates.pop_front();
    compare_field("packed_date", seen.packed_date, want.packed_date);
    compare_field("year_out", seen.year, want.year);
    compare_field("month_out", seen.month, want.month);
    compare_field("day_out", seen.day, want.day);
    compare_field("quarter", seen.quarter, want.quarter);
    compare_field("day_of_year", seen.day_of_year, want.day_of_year);
    compare_field("days_left", seen.days_left, want.days_left);
    compare_field("leap", seen.leap, want.leap);
    compare_field("rejected", seen.rejected, want.rejected);
  endtask
endclass

module tb_calendar_date_register;

  localparam int unsigned TOTAL_ITEMS    = 550;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam logic [26:0] VALUE_MAX      = 27'd99991231;
  localparam int unsigned CENTURY_YEARS [8] =
    '{1700, 1800, 1900, 2000, 2100, 2400, 9600, 9996};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  action = cdr_pkg::ACT_READ;
  logic [26:0] value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [26:0] packed_date;
  logic [13:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [2:0]  quarter;
  logic [8:0]  day_of_year;
  logic [8:0]  days_left;
  logic        leap;
  logic        rejected;

  date_scoreboard sb;
  int unsigned    cycle_count = 0;
  int unsigned    items_sent = 0;
  int unsigned    tx_burst = 0;
  int unsigned    rx_burst = 0;
  bit             rx_hold_req = 0;

  calendar_date_register u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .packed_date (packed_date),
    .year_out    (year_out),
    .month_out   (month_out),
    .day_out     (day_out),
    .quarter     (quarter),
    .day_of_year (day_of_year),
    .days_left   (days_left),
    .leap        (leap),
    .rejected    (rejected)
  );

  always #2 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Idle gap per item, with runs of back-to-back items
  function automatic int unsigned draw_gap(inout int unsigned burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  function automatic int unsigned pick_year();
    case ($urandom_range(0, 7))
      0:       return CENTURY_YEARS[$urandom_range(0, 7)];
      1:       return $urandom_range(1700, 1702);
      2:       return $urandom_range(9997, 9999);
      3:       return $urandom_range(1700, 9999);
      default: return $urandom_range(1895, 2105);
    endcase
  endfunction

  // Packed date, biased to the first and last day of the month
  function automatic logic [26:0] random_date();
    int unsigned y, m, d, len;
    y   = pick_year();
    m   = $urandom_range(1, 12);
    len = month_len(y, m);
    case ($urandom_range(0, 3))
      0:       d = 1;
      1:       d = len;
      default: d = $urandom_range(1, len);
    endcase
    return 27'(y * 10000 + m * 100 + d);
  endfunction

  // Offer one item and hold it until accepted
  task automatic send_item(logic [2:0] act, logic [26:0] val);
    int unsigned gap;
    gap = draw_gap(tx_burst);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    value    <= val;
    do @(posedge clk); while (!in_ready);
    sb.note_item(act, val);
    items_sent++;
  endtask

  // Drop valid and wait until every result is back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, one long hold on request
  initial begin : result_sink
    int unsigned wait_cycles;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (rx_hold_req) begin
        wait_cycles = RX_HOLD_CYCLES;
        rx_hold_req = 0;
      end else begin
        wait_cycles = draw_gap(rx_burst);
      end
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  // Check each result at the edge it is taken
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{packed_date, year_out, month_out, day_out, quarter,
                        day_of_year, days_left, leap, rejected});
  end

  initial begin : item_source
    logic [2:0]  walk_act;
    logic [2:0]  back_act;
    int unsigned pressure_stage;
    sb = new();
    pressure_stage = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: range ends, leap rules, month and year ends, bad operands
    send_item(cdr_pkg::ACT_READ, '0);
    send_item(cdr_pkg::ACT_PREV, VALUE_MAX);
    send_item(cdr_pkg::ACT_LOAD, VALUE_MAX);
    send_item(cdr_pkg::ACT_NEXT, '0);
    send_item(cdr_pkg::ACT_PREV, '0);
    send_item(cdr_pkg::ACT_LOAD, 27'd17000228);
    send_item(cdr_pkg::ACT_LOAD, '0);
    send_item(cdr_pkg::ACT_LOAD, 27'd20000229);
    send_item(cdr_pkg::ACT_SET_YEAR, 27'd1900);
    send_item(cdr_pkg::ACT_SET_YEAR, 27'd2004);
    send_item(cdr_pkg::ACT_SET_YEAR, 27'd10000);
    send_item(cdr_pkg::ACT_SET_YEAR, 27'd1699);
    send_item(cdr_pkg::ACT_SET_MONTH, 27'd0);
    send_item(cdr_pkg::ACT_SET_MONTH, 27'd13);
    send_item(cdr_pkg::ACT_SET_MONTH, 27'd12);
    send_item(cdr_pkg::ACT_SET_DAY, 27'd31);
    send_item(cdr_pkg::ACT_NEXT, '0);
    send_item(cdr_pkg::ACT_SET_YEAR, 27'd1700);
    send_item(cdr_pkg::ACT_PREV, '0);
    send_item(cdr_pkg::ACT_LOAD, 27'd20230131);
    send_item(cdr_pkg::ACT_NEXT, '0);
    send_item(cdr_pkg::ACT_SET_DAY, 27'd0);
    send_item(cdr_pkg::ACT_LOAD, 27'd20240131);
    send_item(cdr_pkg::ACT_SET_MONTH, 27'd2);
    send_item(cdr_pkg::ACT_LOAD, 27'd20231301);
    send_item(cdr_pkg::ACT_LOAD, 27'd21000229);
    send_item(ACT_SPARE, VALUE_MAX);
    wait_drained();

    // Random: mostly date walks, some edits, reads and noise
    while (items_sent < TOTAL_ITEMS) begin
      if (pressure_stage == 0 && items_sent >= 150) begin
        rx_hold_req = 1;
        tx_burst    = 40;
        pressure_stage++;
      end else if (pressure_stage == 1 && items_sent >= 300) begin
        wait_drained();
        pressure_stage++;
      end else if (pressure_stage == 2 && items_sent >= 420) begin
        rx_hold_req = 1;
        tx_burst    = 40;
        pressure_stage++;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          walk_act = $urandom_range(0, 1) ? cdr_pkg::ACT_NEXT : cdr_pkg::ACT_PREV;
          back_act = (walk_act == cdr_pkg::ACT_NEXT) ? cdr_pkg::ACT_PREV : cdr_pkg::ACT_NEXT;
          send_item(cdr_pkg::ACT_LOAD, random_date());
          repeat ($urandom_range(1, 8))
            send_item(($urandom_range(0, 4) == 0) ? back_act : walk_act,
                      27'($urandom_range(0, VALUE_MAX)));
        end
        4: send_item(cdr_pkg::ACT_SET_YEAR, ($urandom_range(0, 4) == 0) ?
                     27'($urandom_range(0, VALUE_MAX)) : 27'(pick_year()));
        5: send_item(cdr_pkg::ACT_SET_MONTH, ($urandom_range(0, 4) == 0) ?
                     27'($urandom_range(0, 15)) : 27'($urandom_range(1, 12)));
        6: send_item(cdr_pkg::ACT_SET_DAY, ($urandom_range(0, 4) == 0) ?
                     27'($urandom_range(0, VALUE_MAX)) : 27'($urandom_range(0, 31)));
        7: send_item($urandom_range(0, 1) ? cdr_pkg::ACT_READ : ACT_SPARE,
                     27'($urandom_range(0, VALUE_MAX)));
        8: send_item(3'($urandom_range(0, 7)), 27'($urandom_range(0, VALUE_MAX)));
        default: begin
          // Walk into either end of the range
          if ($urandom_range(0, 1)) begin
            send_item(cdr_pkg::ACT_LOAD, 27'd99991200 + 27'($urandom_range(28, 31)));
            repeat ($urandom_range(1, 5)) send_item(cdr_pkg::ACT_NEXT, '0);
          end else begin
            send_item(cdr_pkg::ACT_LOAD, 27'd17000300 + 27'($urandom_range(1, 4)));
            repeat ($urandom_range(1, 5)) send_item(cdr_pkg::ACT_PREV, '0);
          end
        end
      endcase
    end

    // Drain, then let stray results show up
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
